// ===== sv/gldp_pkg.sv =====
package gldp_pkg;

	localparam int MAX_SIDE_DEF    = 64;
	localparam int HEIGHT_BITS_DEF = 16;

	localparam int CELL_W  = 16;  // cell_height field
	localparam int LEN_W   = 13;  // route_length field
	localparam int DROP_W  = 16;  // route_drop field
	localparam int CFG_W   = 7;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_RELAX,
		ST_SCAN,
		ST_DONE
	} state_t;

	// steps of one relaxation visit
	localparam logic [2:0] STEP_CTR   = 3'd0;
	localparam logic [2:0] STEP_UP    = 3'd1;
	localparam logic [2:0] STEP_DOWN  = 3'd2;
	localparam logic [2:0] STEP_RIGHT = 3'd3;
	localparam logic [2:0] STEP_LEFT  = 3'd4;
	localparam logic [2:0] STEP_LAST  = 3'd5;
	localparam logic [2:0] STEP_WB    = 3'd6;

endpackage

// ===== sv/grid_longest_descent_path.sv =====
// Height grid in, longest strictly descending 4-neighbor path out. Cells stream in
// row-major at one per cycle; s_tlast on the final cell starts the search and no new
// cell is taken until the result (length, greatest drop among longest paths) has been
// delivered. The search runs on two RAMs (height; best length with lowest end) with
// registered reads: an init pass over every cell, then relaxation sweeps that visit each
// cell in steps (center read, four neighbor reads, a final compare, one write-back)
// repeated until a sweep changes nothing, then a scan of every cell for the answer.
// The number of sweeps is at most the longest path length + 1.
module grid_longest_descent_path
	import gldp_pkg::*;
#(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [CELL_W-1:0]      s_tdata,   // [15:0] cell_height
	input  logic                   s_tlast,   // last_cell
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [12:0] route_length, [28:13] route_drop
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int HB    = HEIGHT_BITS;

	logic [HB-1:0]    hmem [CELLS];
	logic [LW+HB-1:0] pmem [CELLS];   // {best length, lowest end}

	state_t state_q, state_d;
	logic [CFG_W-1:0] width_q, height_q;
	logic [AW-1:0] lp_q, idx_q;
	logic [SW-1:0] r_q, c_q, w_side, h_side;
	logic [2:0]    step_q;
	logic          chg_q;
	logic [HB-1:0] hc_q, end_q, oend_q, hd_s1, ed;
	logic [LW+HB-1:0] pd_s1;
	logic [LW-1:0] len_q, olen_q, ld;
	logic          nv_s1;
	logic [AW-1:0] ra;
	logic          rd_ok;
	logic [LW-1:0] best_len_q;
	logic [HB-1:0] best_drop_q;
	logic          cell_last, row_last, lp_wrap, s_acc;
	logic          l_we;
	logic [LW-1:0] l_wd, cand;
	logic [HB-1:0] e_wd, drop;
	logic          cell_chg;

	always_comb begin
		int wv, hv;
		wv = (width_q == '0) ? 1 : ((int'(width_q) > MAX_SIDE) ? MAX_SIDE : int'(width_q));
		hv = (height_q == '0) ? 1 : ((int'(height_q) > MAX_SIDE) ? MAX_SIDE : int'(height_q));
		w_side = SW'(wv);
		h_side = SW'(hv);
	end

	assign s_acc     = s_tvalid && s_tready;
	assign row_last  = (c_q == w_side - 1'b1);
	assign cell_last = row_last && (r_q == h_side - 1'b1);
	assign lp_wrap   = (int'(lp_q) == CELLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_RESET;
			height_q <= SIDE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_GRID_WIDTH:  width_q  <= cfg_data;
				REG_GRID_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// read address: center, then up, down, right, left
	always_comb begin
		case (step_q)
			STEP_UP:    ra = idx_q - AW'(w_side);
			STEP_DOWN:  ra = idx_q + AW'(w_side);
			STEP_RIGHT: ra = idx_q + 1'b1;
			STEP_LEFT:  ra = idx_q - 1'b1;
			default:    ra = idx_q;
		endcase
		case (step_q)
			STEP_UP:    rd_ok = (r_q != '0);
			STEP_DOWN:  rd_ok = (r_q != h_side - 1'b1);
			STEP_RIGHT: rd_ok = !row_last;
			STEP_LEFT:  rd_ok = (c_q != '0);
			default:    rd_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			hmem[lp_q] <= HB'(s_tdata);
		if (l_we)
			pmem[idx_q] <= {l_wd, e_wd};
		hd_s1 <= hmem[ra];
		pd_s1 <= pmem[ra];
		nv_s1 <= rd_ok;
	end

	assign ld = pd_s1[LW+HB-1:HB];
	assign ed = pd_s1[HB-1:0];

	assign cand = ld + 1'b1;
	assign drop = hd_s1 - ed;
	assign cell_chg = (len_q != olen_q) || (end_q != oend_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (s_acc && s_tlast) state_d = ST_INIT;
			ST_INIT:  if (step_q == STEP_UP && cell_last) state_d = ST_RELAX;
			ST_RELAX: if (step_q == STEP_WB && cell_last && !(chg_q || cell_chg))
				state_d = ST_SCAN;
			ST_SCAN:  if (step_q == STEP_UP && cell_last) state_d = ST_DONE;
			ST_DONE:  if (m_tready) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		l_we     = 1'b0;
		l_wd     = len_q;
		e_wd     = end_q;
		case (state_q)
			ST_LOAD: s_tready = 1'b1;
			ST_INIT: begin
				l_we = (step_q == STEP_UP);
				l_wd = LW'(1);
				e_wd = hd_s1;
			end
			ST_RELAX: l_we = (step_q == STEP_WB);
			ST_DONE:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = {3'b000, DROP_W'(best_drop_q), LEN_W'(best_len_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			lp_q        <= '0;
			idx_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			step_q      <= STEP_CTR;
			chg_q       <= 1'b0;
			best_len_q  <= '0;
			best_drop_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (s_acc)
						lp_q <= (s_tlast || lp_wrap) ? '0 : lp_q + 1'b1;
					idx_q  <= '0;
					r_q    <= '0;
					c_q    <= '0;
					step_q <= STEP_CTR;
					chg_q  <= 1'b0;
				end
				ST_INIT, ST_SCAN, ST_RELAX: begin
					if ((state_q != ST_RELAX && step_q == STEP_UP) ||
					    (state_q == ST_RELAX && step_q == STEP_WB)) begin
						step_q <= STEP_CTR;
						if (cell_last) begin
							idx_q <= '0;
							r_q   <= '0;
							c_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
							c_q   <= row_last ? '0 : c_q + 1'b1;
							r_q   <= row_last ? r_q + 1'b1 : r_q;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
					if (state_q == ST_INIT && step_q == STEP_UP && cell_last)
						chg_q <= 1'b0;
					if (state_q == ST_RELAX && step_q == STEP_WB)
						chg_q <= cell_last ? 1'b0 : (chg_q || cell_chg);
					if (state_q == ST_RELAX && step_q == STEP_WB && cell_last &&
					    !(chg_q || cell_chg)) begin
						best_len_q  <= '0;
						best_drop_q <= '0;
					end
					if (state_q == ST_SCAN && step_q == STEP_UP) begin
						if (ld > best_len_q) begin
							best_len_q  <= ld;
							best_drop_q <= drop;
						end else if (ld == best_len_q && drop > best_drop_q) begin
							best_drop_q <= drop;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// per-cell accumulation during a relaxation visit
	always_ff @(posedge clk) begin
		if (state_q == ST_RELAX) begin
			if (step_q == STEP_UP) begin
				hc_q   <= hd_s1;
				len_q  <= LW'(1);
				end_q  <= hd_s1;
				olen_q <= ld;
				oend_q <= ed;
			end else if (step_q >= STEP_DOWN && step_q <= STEP_LAST) begin
				if (nv_s1 && hc_q > hd_s1) begin
					if (cand > len_q) begin
						len_q <= cand;
						end_q <= ed;
					end else if (cand == len_q && ed < end_q) begin
						end_q <= ed;
					end
				end
			end
		end
	end

endmodule

// ===== sv/gldp_check.sv =====
module gldp_check
	import gldp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [CELL_W-1:0]      s_tdata,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   cfg_we,
	input logic                   cfg_idx,
	input logic [CFG_W-1:0]       cfg_data
);

	// a result is pending only while loading is closed
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("load open while result pending");

	// the last cell closes loading
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready) else $error("load not closed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");

	// every path has at least one cell
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:0] != 13'd0) else $error("zero route length");

endmodule

bind grid_longest_descent_path gldp_check u_gldp_check (.*);

// ===== tb/testbench.sv =====
module testbench;
	import gldp_pkg::*;

	localparam int CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [DROP_W-1:0] drop;
	} route_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [CELL_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	grid_longest_descent_path dut (.*);

	always #1 clk = ~clk;

	// model state
	logic [CELL_W-1:0] heights [CELLS];
	bit                written [CELLS];
	int unsigned       run_len [CELLS];
	logic [CELL_W-1:0] low_end [CELLS];
	int unsigned load_pos = 0;
	logic [CFG_W-1:0] side_w = SIDE_RESET, side_h = SIDE_RESET;

	route_t expected_routes [$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int cells_sent = 0;
	int ready_mode = 0;

	function automatic int clamp_side(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
		return v;
	endfunction

	function automatic void offer(logic [CELL_W-1:0] h, int n, ref int unsigned len,
			ref logic [CELL_W-1:0] e);
		if (h > heights[n]) begin
			if (run_len[n] + 1 > len) begin
				len = run_len[n] + 1;
				e = low_end[n];
			end else if (run_len[n] + 1 == len && low_end[n] < e) begin
				e = low_end[n];
			end
		end
	endfunction

	// relax per-cell best length and lowest end until stable, then pick the answer
	function automatic route_t longest_descent();
		int w, hg, idx;
		int unsigned len, best_len;
		logic [CELL_W-1:0] e, drop, best_drop;
		bit changed;
		route_t r;
		w = clamp_side(side_w);
		hg = clamp_side(side_h);
		for (int i = 0; i < w * hg; i++) begin
			run_len[i] = 1;
			low_end[i] = heights[i];
		end
		do begin
			changed = 0;
			for (int row = 0; row < hg; row++)
				for (int col = 0; col < w; col++) begin
					idx = row * w + col;
					len = 1;
					e = heights[idx];
					if (row > 0) offer(heights[idx], idx - w, len, e);
					if (row + 1 < hg) offer(heights[idx], idx + w, len, e);
					if (col + 1 < w) offer(heights[idx], idx + 1, len, e);
					if (col > 0) offer(heights[idx], idx - 1, len, e);
					if (len != run_len[idx] || e != low_end[idx]) begin
						run_len[idx] = len;
						low_end[idx] = e;
						changed = 1;
					end
				end
		end while (changed);
		best_len = 0;
		best_drop = 0;
		for (int i = 0; i < w * hg; i++) begin
			drop = heights[i] - low_end[i];
			if (run_len[i] > best_len) begin
				best_len = run_len[i];
				best_drop = drop;
			end else if (run_len[i] == best_len && drop > best_drop) begin
				best_drop = drop;
			end
		end
		r.len = best_len[LEN_W-1:0];
		r.drop = best_drop;
		return r;
	endfunction

	task automatic send_cell(logic [CELL_W-1:0] h, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= h;
		s_tlast <= last;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		heights[load_pos] = h;
		written[load_pos] = 1;
		load_pos = (load_pos + 1) % CELLS;
		cells_sent++;
		if (last) begin
			load_pos = 0;
			expected_routes = {expected_routes, longest_descent()};
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_routes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_GRID_WIDTH) side_w = v;
		else side_h = v;
	endtask

	task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		drain();
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// heights: 0 = full range, else 0..range
	task automatic send_grid(int count, int range);
		for (int i = 0; i < count; i++)
			send_cell(range == 0 ? CELL_W'($urandom) : CELL_W'($urandom_range(0, range)),
				i == count - 1);
	endtask

	task automatic test_directed();
		int n;
		set_size(1, 1);
		send_cell('1, 1'b1);
		send_cell('0, 1'b1);
		set_size(3, 3);
		for (int i = 0; i < 9; i++) send_cell(16'h1234, i == 8);   // flat grid
		for (int i = 0; i < 9; i++) send_cell(i[0] ? 16'hFFFF : 16'h0000, i == 8);
		set_size(64, 1);
		for (int i = 0; i < 64; i++) send_cell(CELL_W'(64 - i) * 16'd1000, i == 63);
		set_size(1, 64);
		for (int i = 0; i < 64; i++) send_cell(CELL_W'(i) * 16'd1023, i == 63);
		// 8x8 grid falling right and down, with small per-cell offsets
		set_size(8, 8);
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) begin
				n = r * 8 + (r[0] ? 7 - c : c);
				send_cell(CELL_W'(65535 - 1000 * (r * 8 + c) - 100 * (n % 3)), r == 7 && c == 7);
			end
	endtask

	task automatic test_size_edges();
		set_size(0, 0);      // zero acts as one
		send_cell(16'hA5A5, 1'b1);
		set_size(127, 1);    // above max acts as max
		send_grid(64, 0);
		set_size(2, 127);
		send_grid(128, 7);
		set_size(4, 4);
		send_grid(16 + 5, 3);  // extra cells past the grid
		// short grid: remaining cells come from the previous load
		send_grid(6, 3);
	endtask

	task automatic test_random();
		int w, h, n;
		while (cells_sent < 680) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			set_size(CFG_W'(w), CFG_W'(h));
			n = w * h;
			case ($urandom_range(0, 5))
				0: n = n + $urandom_range(1, 8);
				1: begin
					n = $urandom_range(1, n);
					for (int i = n; i < w * h; i++) if (!written[i]) n = w * h;
				end
				default: ;
			endcase
			send_grid(n, $urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
			if ($urandom_range(0, 3) == 0) send_grid(n, 0);
		end
	endtask

	always @(posedge clk) begin
		if (($urandom_range(0, 255) == 0)) ready_mode <= $urandom_range(0, 2);
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		route_t want;
		if (m_tvalid && m_tready) begin
			if (expected_routes.size() == 0) begin
				$display("%0t: unexpected route len=%0d drop=%0d", $time,
					m_tdata[12:0], m_tdata[28:13]);
				errors++;
			end else begin
				want = expected_routes.pop_front();
				if (m_tdata[12:0] !== want.len) begin
					$display("%0t: route_length expected %0d got %0d", $time, want.len,
						m_tdata[12:0]);
					errors++;
				end
				if (m_tdata[28:13] !== want.drop) begin
					$display("%0t: route_drop expected %0d got %0d", $time, want.drop,
						m_tdata[28:13]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_edges();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_routes.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gldp_pkg.sv
sv/grid_longest_descent_path.sv
sv/gldp_check.sv
tb/testbench.sv
